// ===== hdl/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg
// shared constants and command codes for the stuffed bit reader
// ----------------------------------------------------------------------------
package sbr_pkg;

   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   localparam int MAX_BITS    = 32;
   localparam int WANT_W      = 6;
   localparam int BYTE_W      = 8;

   // command codes
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_SKIP = 2'd2;

   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hff;
   localparam logic [BYTE_W-1:0] STUFF_BYTE  = 8'h00;

endpackage

// ===== hdl/sbr_if.sv =====
// ----------------------------------------------------------------------------
// sbr_req_if / sbr_rsp_if
// valid/ready channels for request and response beats
// ----------------------------------------------------------------------------
interface sbr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] load_byte;
   logic [5:0] bit_count;
   logic       remove_stuffing;
   logic [7:0] sought_byte;

   modport source (output valid, cmd, load_byte, bit_count, remove_stuffing, sought_byte,
                   input ready);
   modport sink   (input valid, cmd, load_byte, bit_count, remove_stuffing, sought_byte,
                   output ready);
endinterface

interface sbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [5:0]  bits_taken;
   logic        at_end;
   logic        not_found;

   modport source (output valid, value, bits_taken, at_end, not_found, input ready);
   modport sink   (input valid, value, bits_taken, at_end, not_found, output ready);
endinterface

// ===== hdl/sbr_ram.sv =====
// ----------------------------------------------------------------------------
// sbr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/stuffed_bit_reader.sv =====
// ----------------------------------------------------------------------------
// stuffed_bit_reader
// bit reader over a loaded byte store with 0xff/0x00 byte unstuffing
// ----------------------------------------------------------------------------
//
//  port     dir   beat carries
//  -------  ----  ---------------------------------------------------------
//  req_ch   in    cmd, load_byte, bit_count, remove_stuffing, sought_byte
//  rsp_ch   out   value, bits_taken, at_end, not_found (read and skip only)
//
//  a load is written to the store as it is taken. a read touches up to 5
//  bytes and looks ahead for stuffing up to 4 times; a skip moves on one
//  byte at a time. the pace is set by the byte store's single read port,
//  which delivers one byte a cycle. reset clears the state, the response
//  valid flag, the counters and positions only; the store needs no clear
//  since only bytes below the fill count are ever read.
//  a finished response waits in the output register; a new beat is taken
//  meanwhile, and the engine stalls only when a second response is ready.
//
module stuffed_bit_reader (
   input logic        clock,
   input logic        reset,
   sbr_req_if.sink    req_ch,
   sbr_rsp_if.source  rsp_ch
);

   import sbr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_STUFF,
      ST_SKIP
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       read_pos_ff, read_pos_in;
   logic [2:0]             bit_pos_ff, bit_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic [WANT_W-1:0]      want_ff, want_in;
   logic [WANT_W-1:0]      taken_ff, taken_in;
   logic [MAX_BITS-1:0]    value_ff, value_in;
   logic                   unstuff_ff, unstuff_in;
   logic [BYTE_W-1:0]      sought_ff, sought_in;

   // response payload
   logic [MAX_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic [WANT_W-1:0]      rsp_taken_ff, rsp_taken_in;
   logic                   rsp_end_ff, rsp_end_in;
   logic                   rsp_nf_ff, rsp_nf_in;

   // store ports
   logic                   wr_en;
   logic [BYTE_W-1:0]      rd_data;

   // datapath helpers
   logic                   data_done;
   logic                   slot_free;
   logic [3:0]             avail;
   logic [WANT_W-1:0]      remain;
   logic [3:0]             nbits;
   logic [BYTE_W-1:0]      aligned;
   logic [BYTE_W-1:0]      chunk;
   logic [3:0]             bit_sum;
   logic [CNT_W-1:0]       pos_next;

   // the store is read every cycle at the position the engine will sit on
   // next, so rd_data always holds the byte under read_pos_ff
   sbr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_ch.load_byte),
      .rd_addr (read_pos_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign wr_en = req_ch.valid && req_ch.ready && (req_ch.cmd == CMD_LOAD) &&
                  (fill_ff < CNT_W'(STORE_DEPTH));

   assign data_done = (read_pos_ff >= fill_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign pos_next  = read_pos_ff + 1'b1;

   // bits taken from the current byte this cycle
   assign avail   = 4'd8 - {1'b0, bit_pos_ff};
   assign remain  = want_ff - taken_ff;
   assign nbits   = (WANT_W'(avail) < remain) ? avail : remain[3:0];
   assign aligned = rd_data << bit_pos_ff;
   assign chunk   = aligned >> (4'd8 - nbits);
   assign bit_sum = {1'b0, bit_pos_ff} + nbits;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      read_pos_in  = read_pos_ff;
      bit_pos_in   = bit_pos_ff;
      want_in      = want_ff;
      taken_in     = taken_ff;
      value_in     = value_ff;
      unstuff_in   = unstuff_ff;
      sought_in    = sought_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_taken_in = rsp_taken_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_nf_in    = rsp_nf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               want_in    = (req_ch.bit_count > WANT_W'(MAX_BITS)) ?
                            WANT_W'(MAX_BITS) : req_ch.bit_count;
               taken_in   = '0;
               value_in   = '0;
               unstuff_in = req_ch.remove_stuffing;
               sought_in  = req_ch.sought_byte;
               case (req_ch.cmd)
                  CMD_LOAD: begin
                     if (wr_en) begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  CMD_READ: state_in = ST_READ;
                  CMD_SKIP: state_in = ST_SKIP;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end

         ST_READ: begin
            if ((taken_ff == want_ff) || data_done) begin
               // finished: hand over once the output register frees up
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = value_ff;
                  rsp_taken_in = taken_ff;
                  rsp_end_in   = data_done;
                  rsp_nf_in    = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               value_in = (value_ff << nbits) | MAX_BITS'(chunk);
               taken_in = taken_ff + WANT_W'(nbits);
               if (bit_sum == 4'd8) begin
                  read_pos_in = pos_next;
                  bit_pos_in  = '0;
                  // look at the following byte only if it was loaded
                  if (unstuff_ff && (rd_data == MARKER_BYTE) && (pos_next < fill_ff)) begin
                     state_in = ST_STUFF;
                  end
               end else begin
                  bit_pos_in = bit_sum[2:0];
               end
            end
         end

         ST_STUFF: begin
            // byte after a marker: drop it if it is a stuffed zero
            if (rd_data == STUFF_BYTE) begin
               read_pos_in = pos_next;
            end
            state_in = ST_READ;
         end

         ST_SKIP: begin
            if (data_done || (rd_data == sought_ff)) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_taken_in = '0;
                  rsp_end_in   = data_done;
                  rsp_nf_in    = data_done;
                  state_in     = ST_IDLE;
               end
            end else begin
               read_pos_in = pos_next;
               bit_pos_in  = '0;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         read_pos_ff  <= '0;
         bit_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         read_pos_ff  <= read_pos_in;
         bit_pos_ff   <= bit_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      want_ff      <= want_in;
      taken_ff     <= taken_in;
      value_ff     <= value_in;
      unstuff_ff   <= unstuff_in;
      sought_ff    <= sought_in;
      rsp_value_ff <= rsp_value_in;
      rsp_taken_ff <= rsp_taken_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_nf_ff    <= rsp_nf_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.value      = rsp_value_ff;
   assign rsp_ch.bits_taken = rsp_taken_ff;
   assign rsp_ch.at_end     = rsp_end_ff;
   assign rsp_ch.not_found  = rsp_nf_ff;

   // the read position never runs past the loaded data
   a_pos_in_data: assert property (@(posedge clock) disable iff (reset)
      read_pos_ff <= fill_ff)
      else $error("read position beyond fill count");

   // the end of data is only ever reached on a byte boundary
   a_end_aligned: assert property (@(posedge clock) disable iff (reset)
      (read_pos_ff == fill_ff) |-> (bit_pos_ff == 3'd0))
      else $error("end of data reached inside a byte");

   // a failed skip always reports the end of data as well
   a_nf_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (!rsp_ch.not_found || rsp_ch.at_end))
      else $error("not_found without at_end");

   // a read never returns more bits than were asked for
   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (taken_ff <= want_ff))
      else $error("read took more bits than requested");

endmodule

// ===== tb/stuffed_bit_reader_tb.sv =====
// ----------------------------------------------------------------------------
// stuffed_bit_reader_tb
// self-checking bench: byte loads, msb-first bit reads with unstuffing and
// byte skips are driven with random gaps and back-pressure, and every
// response beat is compared against a behavioral copy of the reader
// ----------------------------------------------------------------------------
module stuffed_bit_reader_tb;
   import sbr_pkg::*;

   // cmd 3 is not a real command: the block must swallow it silently
   localparam logic [1:0] CMD_NONE = 2'd3;

   // never produced by the random byte stream, so the loads that land on a
   // full store can be recognized: a skip for it must run off the end
   localparam logic [BYTE_W-1:0] FILL_TAG = 8'hee;

   localparam int RANDOM_ITEMS    = 1500;
   localparam int RANDOM_BYTE_CAP = 2000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 20000;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [BYTE_W-1:0] load_byte;
      logic [WANT_W-1:0] bit_count;
      logic              remove_stuffing;
      logic [BYTE_W-1:0] sought_byte;
   } req_beat_type;

   typedef struct packed {
      logic [MAX_BITS-1:0] value;
      logic [WANT_W-1:0]   bits_taken;
      logic                at_end;
      logic                not_found;
   } rsp_beat_type;

   logic clock;
   logic reset = 1'b1;

   sbr_req_if req_ch ();
   sbr_rsp_if rsp_ch ();

   stuffed_bit_reader u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // behavioral copy of the reader state
   logic [BYTE_W-1:0] store_copy [STORE_DEPTH];
   int unsigned       fill_level = 0;
   int unsigned       byte_idx   = 0;
   int unsigned       bit_idx    = 0;   // 0 is the msb of the current byte

   req_beat_type req_backlog [$];   // beats waiting to be driven
   rsp_beat_type results_due [$];   // predicted responses, oldest first
   req_beat_type beat_on_bus;

   int beats_planned  = 0;
   int beats_accepted = 0;
   int items_queued   = 0;       // counts beats the block acts on
   int bytes_queued   = 0;
   int mismatches     = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   int stuck_cycles   = 0;
   bit calm_stretch   = 1'b0;    // no idling on either side while set

   // ----------------------------------------------------------------------
   // reader behavior, applied to each accepted request beat
   // ----------------------------------------------------------------------
   task automatic advance_reader(input req_beat_type rq);
      rsp_beat_type      rs;
      int unsigned       want;
      int unsigned       taken;
      logic [BYTE_W-1:0] cur;
      rs    = '0;
      taken = 0;
      case (rq.cmd)
         CMD_LOAD: begin
            // a full store drops the byte
            if (fill_level < STORE_DEPTH) begin
               store_copy[fill_level] = rq.load_byte;
               fill_level++;
            end
         end
         CMD_READ: begin
            want = (rq.bit_count > MAX_BITS) ? MAX_BITS : rq.bit_count;
            while (taken != want && byte_idx < fill_level) begin
               cur      = store_copy[byte_idx];
               rs.value = {rs.value[MAX_BITS-2:0], cur[7 - bit_idx]};
               taken++;
               if (bit_idx == 7) begin
                  bit_idx = 0;
                  byte_idx++;
                  // stuffed zero after a marker, only if it is already loaded
                  if (rq.remove_stuffing && cur == MARKER_BYTE && byte_idx < fill_level &&
                      store_copy[byte_idx] == STUFF_BYTE)
                     byte_idx++;
               end else begin
                  bit_idx++;
               end
            end
            rs.bits_taken = WANT_W'(taken);
            rs.at_end     = (byte_idx >= fill_level);
            results_due.push_back(rs);
         end
         CMD_SKIP: begin
            // bit position survives a skip that is already on its byte
            while (byte_idx < fill_level && store_copy[byte_idx] != rq.sought_byte) begin
               byte_idx++;
               bit_idx = 0;
            end
            rs.at_end    = (byte_idx >= fill_level);
            rs.not_found = rs.at_end;
            results_due.push_back(rs);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // ----------------------------------------------------------------------
   // stimulus helpers
   // ----------------------------------------------------------------------

   // unused fields of a beat carry random bits so the block must ignore them
   function automatic req_beat_type random_beat();
      req_beat_type b;
      b.cmd             = 2'($urandom_range(0, 3));
      b.load_byte       = BYTE_W'($urandom_range(0, 255));
      b.bit_count       = WANT_W'($urandom_range(0, 63));
      b.remove_stuffing = 1'($urandom_range(0, 1));
      b.sought_byte     = BYTE_W'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic queue_beat(input req_beat_type b);
      req_backlog.push_back(b);
      if (b.cmd != CMD_NONE) items_queued++;
   endtask

   task automatic push_load(input logic [BYTE_W-1:0] data);
      req_beat_type b;
      b           = random_beat();
      b.cmd       = CMD_LOAD;
      b.load_byte = data;
      bytes_queued++;
      queue_beat(b);
   endtask

   task automatic push_read(input int unsigned count, input bit unstuff);
      req_beat_type b;
      b                 = random_beat();
      b.cmd             = CMD_READ;
      b.bit_count       = WANT_W'(count);
      b.remove_stuffing = unstuff;
      queue_beat(b);
   endtask

   task automatic push_skip(input logic [BYTE_W-1:0] sought);
      req_beat_type b;
      b             = random_beat();
      b.cmd         = CMD_SKIP;
      b.sought_byte = sought;
      queue_beat(b);
   endtask

   task automatic push_noop();
      req_beat_type b;
      b     = random_beat();
      b.cmd = CMD_NONE;
      queue_beat(b);
   endtask

   // compressed-looking data with markers and zeros, never the fill tag
   function automatic logic [BYTE_W-1:0] stream_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) b = MARKER_BYTE;
      else if ($urandom_range(0, 9) == 0) b = STUFF_BYTE;
      return (b == FILL_TAG) ? b + 8'd1 : b;
   endfunction

   // mostly short reads, some full words, a few empty and oversized ones
   function automatic int unsigned read_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)  return 0;
      if (pick < 70) return $urandom_range(1, 16);
      if (pick < 90) return $urandom_range(17, MAX_BITS);
      return $urandom_range(MAX_BITS + 1, 63);
   endfunction

   function automatic logic [BYTE_W-1:0] seek_target();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return MARKER_BYTE;
      if (pick < 8) return BYTE_W'(8'hd0 + $urandom_range(0, 7));
      return stream_byte();
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (calm_stretch || pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // ----------------------------------------------------------------------
   // clock and reset
   // ----------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // switch between idling and back-to-back stretches now and then
   always @(posedge clock) begin
      if (reset) begin
         calm_stretch <= 1'b0;
      end else if ($urandom_range(0, 399) == 0) begin
         calm_stretch <= ~calm_stretch;
      end
   end

   // ----------------------------------------------------------------------
   // request driver: predicts on acceptance, then moves to the next beat
   // ----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            advance_reader(beat_on_bus);
            beats_accepted <= beats_accepted + 1;
         end
         // bus is free once the current beat is taken or nothing is offered
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               req_ch.valid <= 1'b0;
               send_gap     <= send_gap - 1;
            end else if (req_backlog.size() != 0) begin
               beat_on_bus             = req_backlog.pop_front();
               req_ch.valid           <= 1'b1;
               req_ch.cmd             <= beat_on_bus.cmd;
               req_ch.load_byte       <= beat_on_bus.load_byte;
               req_ch.bit_count       <= beat_on_bus.bit_count;
               req_ch.remove_stuffing <= beat_on_bus.remove_stuffing;
               req_ch.sought_byte     <= beat_on_bus.sought_byte;
               send_gap               <= gap_length();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // response monitor with random back-pressure
   // ----------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (results_due.size() == 0) begin
               $error("response beat with no result pending");
               mismatches++;
            end else begin
               want = results_due.pop_front();
               check_field("value", want.value, rsp_ch.value);
               check_field("bits_taken", 32'(want.bits_taken), 32'(rsp_ch.bits_taken));
               check_field("at_end", 32'(want.at_end), 32'(rsp_ch.at_end));
               check_field("not_found", 32'(want.not_found), 32'(rsp_ch.not_found));
            end
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else if (!calm_stretch && $urandom_range(0, 99) < 30) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= gap_length();
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ----------------------------------------------------------------------
   // watchdog: too long without any beat on either side
   // ----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ----------------------------------------------------------------------
   // stimulus plan and end of run
   // ----------------------------------------------------------------------
   initial begin
      int n_bytes;
      int n_ops;
      int pick;

      req_ch.valid           = 1'b0;
      req_ch.cmd             = CMD_LOAD;
      req_ch.load_byte       = '0;
      req_ch.bit_count       = '0;
      req_ch.remove_stuffing = 1'b0;
      req_ch.sought_byte     = '0;
      rsp_ch.ready           = 1'b0;

      // empty store: a read returns nothing, a skip finds nothing
      push_read(5, 1'b1);
      push_skip(STUFF_BYTE);
      push_noop();

      // a5 ff 00 3c: stuffed zero in the middle
      push_load(8'ha5);
      push_load(MARKER_BYTE);
      push_load(STUFF_BYTE);
      push_load(8'h3c);
      push_read(0, 1'b1);          // zero-bit read leaves the state alone
      push_read(4, 1'b1);
      push_skip(8'ha5);            // already on its byte, bit offset kept
      push_skip(MARKER_BYTE);      // moves one byte, bit offset cleared
      push_read(63, 1'b1);         // oversized, clipped, stops at data end

      // marker as the last loaded byte: the later zero is plain data
      push_load(MARKER_BYTE);
      push_read(8, 1'b1);
      push_load(STUFF_BYTE);
      push_read(8, 1'b1);

      // unstuffing off: the zero after a marker is read as data
      push_load(MARKER_BYTE);
      push_load(STUFF_BYTE);
      push_load(8'h81);
      push_read(20, 1'b0);
      push_read(MAX_BITS, 1'b1);

      // random part: mostly load bursts followed by reads and skips
      items_queued = 0;
      while (items_queued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            // noise: lone commands, often past the end of the data
            case ($urandom_range(0, 2))
               0:       push_read($urandom_range(0, 63), 1'($urandom_range(0, 1)));
               1:       push_skip(BYTE_W'($urandom_range(0, 255)));
               default: push_noop();
            endcase
         end else begin
            n_bytes = $urandom_range(1, 10);
            for (int i = 0; i < n_bytes && bytes_queued < RANDOM_BYTE_CAP - 1; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 15) begin
                  push_load(MARKER_BYTE);
                  push_load(STUFF_BYTE);
               end else if (pick < 25) begin
                  push_load(MARKER_BYTE);
                  push_load(BYTE_W'(8'hd0 + $urandom_range(0, 7)));
               end else begin
                  push_load(stream_byte());
               end
            end
            n_ops = $urandom_range(1, 6);
            for (int i = 0; i < n_ops; i++) begin
               if ($urandom_range(0, 4) == 0) push_skip(seek_target());
               else push_read(read_len(), $urandom_range(0, 9) != 0);
            end
         end
      end

      // fill the store to the brim, then overflow it with tagged bytes
      while (bytes_queued < STORE_DEPTH) begin
         push_load(stream_byte());
         if ($urandom_range(0, 199) == 0) push_read(read_len(), 1'b1);
      end
      for (int i = 0; i < 3; i++) push_load(FILL_TAG);
      for (int i = 0; i < 6; i++) push_read(MAX_BITS, 1'b1);
      push_skip(MARKER_BYTE);
      push_skip(FILL_TAG);         // dropped bytes must not be found
      push_read(MAX_BITS, 1'b1);
      push_skip(MARKER_BYTE);

      beats_planned = req_backlog.size();

      do @(posedge clock);
      while (beats_accepted != beats_planned || results_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (results_due.size() != 0) begin
         $error("%0d predicted responses never arrived", results_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
